FILE: rtl/core/assert_macros.svh
// assertion macros used by the scheduler core of the round-robin slicer
// no dependencies; assertions compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RRTS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("rrts assertion failed");
`define RRTS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rrts implication failed");
`else
`define RRTS_ASSERT(lbl, clk_s, rst_s, prop)
`define RRTS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

FILE: rtl/core/rrts_pkg.sv
// shared types, widths and codes of the round-robin slicer
// no dependencies
`default_nettype none

package rrts_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int ID_W     = 8;
  localparam int TIME_W   = 16;
  localparam int BURST_W  = 12;
  localparam int QUANT_W  = 12;
  localparam int STATUS_W = 2;
  localparam int STAT_W   = 18;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SLICE = 2'd0,
    ST_LOAD  = 2'd1,
    ST_FULL  = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  // one row of the process table
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/rrts_intf.sv
// request, result and configuration channel interfaces of the slicer
// depends on rrts_pkg
`default_nettype none

interface rrts_req_if import rrts_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [ID_W-1:0]    process_id;
  logic [TIME_W-1:0]  arrival_stamp;
  logic [BURST_W-1:0] burst_len;

  modport source (output valid, operation, process_id, arrival_stamp, burst_len,
                  input ready);
  modport sink   (input valid, operation, process_id, arrival_stamp, burst_len,
                  output ready);
endinterface

interface rrts_res_if import rrts_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ID_W-1:0]          served_id;
  logic [TIME_W-1:0]        slice_start;
  logic [BURST_W-1:0]       slice_length;
  logic                     finished;
  logic signed [STAT_W-1:0] turnaround;
  logic signed [STAT_W-1:0] waiting;

  modport source (output valid, status, served_id, slice_start, slice_length,
                  finished, turnaround, waiting, input ready);
  modport sink   (input valid, status, served_id, slice_start, slice_length,
                  finished, turnaround, waiting, output ready);
endinterface

interface rrts_cfg_if import rrts_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [QUANT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/round_robin_time_slicer_top.sv
// Round-robin time slicer, top level.
// Channels: req carries one request (load a process or run the next slice),
// res returns exactly one result per request, cfg writes the time quantum
// (always ready; to be written only while no request is in flight).
// A load goes through the emit state into the output register, and the next
// request is taken only once the core is back in idle.
// A step scans the process table memory from the entry after the last one
// served, one entry per cycle through the single read port, then books the
// slice, forms turnaround and waiting, and loads the output register. A step
// with nothing left goes from idle straight to the emit state.
// One request is in flight at a time; req.ready is high while the core idles,
// which includes while a finished result still waits on res.
// Reset empties the table (counts, scan pointer and time go to zero) and sets
// the quantum to 1; the table rows need no clearing since only loaded rows
// are read. If res stalls, the next result waits in the core until the
// output register frees, and no further request is taken meanwhile.
// depends on rrts_pkg, rrts_intf and rrts_sched
`default_nettype none

module round_robin_time_slicer_top import rrts_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rrts_cfg_if.sink   cfg,
  rrts_req_if.sink   req,
  rrts_res_if.source res
);

  logic [QUANT_W-1:0] slice_quantum;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_quantum <= QUANT_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      slice_quantum <= cfg.data;
    end
  end

  rrts_sched #(
    .MAX_PROCS (MAX_PROCS)
  ) u_sched (
    .clk           (clk),
    .rst           (rst),
    .slice_quantum (slice_quantum),
    .req           (req),
    .res           (res)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rrts_sched.sv
// scheduler core: process table memory, scan sequencer and result register
// depends on rrts_pkg, rrts_intf and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rrts_sched import rrts_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [QUANT_W-1:0] slice_quantum,
  rrts_req_if.sink           req,
  rrts_res_if.source         res
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_CALC,
    S_EMIT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    loaded_count;
  logic [CNT_W-1:0]    unfinished_count;
  logic [IDX_W-1:0]    scan_pointer;
  logic [TIME_W-1:0]   clock_now;

  logic [IDX_W-1:0]    ptr;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_vld;
  logic [IDX_W-1:0]    sel;
  entry_t              hit;

  status_t                  pend_status;
  logic [ID_W-1:0]          pend_id;
  logic [TIME_W-1:0]        pend_start;
  logic [BURST_W-1:0]       pend_len;
  logic                     pend_fin;
  logic signed [STAT_W-1:0] pend_tat;
  logic signed [STAT_W-1:0] pend_wt;

  logic                     res_valid;
  status_t                  out_status;
  logic [ID_W-1:0]          out_id;
  logic [TIME_W-1:0]        out_start;
  logic [BURST_W-1:0]       out_len;
  logic                     out_fin;
  logic signed [STAT_W-1:0] out_tat;
  logic signed [STAT_W-1:0] out_wt;

  entry_t mem [MAX_PROCS];
  entry_t rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic                     acc;
  logic                     room;
  logic                     emit_go;
  logic [QUANT_W-1:0]       q_eff;
  logic [BURST_W-1:0]       len_c;
  logic [CNT_W-1:0]         ptr_inc;
  logic [IDX_W-1:0]         ptr_wrap;
  logic [CNT_W-1:0]         sel_inc;
  logic [IDX_W-1:0]         sel_wrap;
  logic [IDX_W-1:0]         start_idx;
  logic signed [STAT_W-1:0] tat_c;
  logic signed [STAT_W-1:0] wt_c;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign room      = (loaded_count < CNT_MAX);
  assign emit_go   = (state == S_EMIT) && (!res_valid || res.ready);

  // a zero quantum behaves as one
  assign q_eff = (slice_quantum == '0) ? QUANT_W'(1) : slice_quantum;
  assign len_c = (hit.remaining <= q_eff) ? hit.remaining : q_eff;

  assign ptr_inc   = CNT_W'(ptr) + CNT_W'(1);
  assign ptr_wrap  = (ptr_inc >= loaded_count) ? '0 : ptr_inc[IDX_W-1:0];
  assign sel_inc   = CNT_W'(sel) + CNT_W'(1);
  assign sel_wrap  = (sel_inc >= loaded_count) ? '0 : sel_inc[IDX_W-1:0];
  assign start_idx = (CNT_W'(scan_pointer) < loaded_count) ? scan_pointer : '0;

  // completion time is clock_now once the slice has been booked
  assign tat_c = $signed({2'b00, clock_now}) - $signed({2'b00, hit.arrival});
  assign wt_c  = tat_c - $signed({6'b000000, hit.burst});

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sel;
    mem_wdata = hit;
    if (state == S_IDLE && acc && req.operation == OP_LOAD && room) begin
      mem_we              = 1'b1;
      mem_waddr           = loaded_count[IDX_W-1:0];
      mem_wdata.id        = req.process_id;
      mem_wdata.arrival   = req.arrival_stamp;
      mem_wdata.burst     = req.burst_len;
      mem_wdata.remaining = req.burst_len;
    end else if (state == S_UPD) begin
      mem_we              = 1'b1;
      mem_wdata.remaining = hit.remaining - len_c;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      loaded_count     <= '0;
      unfinished_count <= '0;
      scan_pointer     <= '0;
      clock_now        <= '0;
      rd_vld           <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (emit_go) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            pend_id    <= '0;
            pend_start <= '0;
            pend_len   <= '0;
            pend_fin   <= 1'b0;
            pend_tat   <= '0;
            pend_wt    <= '0;
            if (req.operation == OP_LOAD) begin
              if (room) begin
                loaded_count <= loaded_count + CNT_W'(1);
                if (req.burst_len != '0) begin
                  unfinished_count <= unfinished_count + CNT_W'(1);
                end
                pend_status <= ST_LOAD;
              end else begin
                pend_status <= ST_FULL;
              end
              state <= S_EMIT;
            end else if (unfinished_count == '0) begin
              // nothing left: report and empty the table
              loaded_count     <= '0;
              unfinished_count <= '0;
              scan_pointer     <= '0;
              clock_now        <= '0;
              pend_status      <= ST_DONE;
              state            <= S_EMIT;
            end else begin
              ptr    <= start_idx;
              rd_vld <= 1'b0;
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // one read issued per cycle, its data checked in the next cycle
          rd_idx <= ptr;
          rd_vld <= 1'b1;
          ptr    <= ptr_wrap;
          if (rd_vld && rdata.remaining != '0) begin
            hit   <= rdata;
            sel   <= rd_idx;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          clock_now    <= clock_now + TIME_W'(len_c);
          pend_status  <= ST_SLICE;
          pend_id      <= hit.id;
          pend_start   <= clock_now;
          pend_len     <= len_c;
          pend_fin     <= (hit.remaining == len_c);
          if (hit.remaining == len_c && unfinished_count != '0) begin
            unfinished_count <= unfinished_count - CNT_W'(1);
          end
          scan_pointer <= sel_wrap;
          state        <= S_CALC;
        end
        S_CALC: begin
          if (pend_fin) begin
            pend_tat <= tat_c;
            pend_wt  <= wt_c;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_status <= pend_status;
            out_id     <= pend_id;
            out_start  <= pend_start;
            out_len    <= pend_len;
            out_fin    <= pend_fin;
            out_tat    <= pend_tat;
            out_wt     <= pend_wt;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid        = res_valid;
  assign res.status       = out_status;
  assign res.served_id    = out_id;
  assign res.slice_start  = out_start;
  assign res.slice_length = out_len;
  assign res.finished     = out_fin;
  assign res.turnaround   = out_tat;
  assign res.waiting      = out_wt;

  `RRTS_ASSERT(a_unfin_le_loaded, clk, rst, unfinished_count <= loaded_count)
  `RRTS_ASSERT(a_loaded_bound, clk, rst, loaded_count <= CNT_MAX)
  `RRTS_ASSERT_IMP(a_scan_in_table, clk, rst, state == S_SCAN && rd_vld,
                   CNT_W'(rd_idx) < loaded_count)
  `RRTS_ASSERT_IMP(a_slice_nonzero, clk, rst, state == S_UPD, len_c != '0)
  `RRTS_ASSERT_IMP(a_done_clears, clk, rst,
                   acc && req.operation == OP_STEP && unfinished_count == '0,
                   ##1 loaded_count == '0)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// self-checking bench for the round-robin time slicer: a directed request table, then
// random load/step runs, each result checked against a typed status or an in-bench model
// depends on rrts_pkg, rrts_intf and round_robin_time_slicer_top
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int NPROC         = MAX_PROCS_DEF;
  localparam int SHOW_LIMIT    = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 2 * NPROC + 10;
  localparam int PHASE_ITEMS   = 205;

  typedef struct packed {
    status_t                  status;
    logic [ID_W-1:0]          served_id;
    logic [TIME_W-1:0]        slice_start;
    logic [BURST_W-1:0]       slice_length;
    logic                     finished;
    logic signed [STAT_W-1:0] turnaround;
    logic signed [STAT_W-1:0] waiting;
  } slice_res_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               op;
    logic [ID_W-1:0]    pid;
    logic [TIME_W-1:0]  arr;
    logic [BURST_W-1:0] burst;
    logic [QUANT_W-1:0] qval;
    bit                 typed;
    status_t            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  rrts_cfg_if cfg_ch ();
  rrts_req_if req_ch ();
  rrts_res_if res_ch ();

  round_robin_time_slicer_top dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler model state
  logic [ID_W-1:0]    tab_id      [NPROC];
  logic [TIME_W-1:0]  tab_arrival [NPROC];
  logic [BURST_W-1:0] tab_burst   [NPROC];
  logic [BURST_W-1:0] tab_left    [NPROC];
  int                 n_loaded;
  int                 n_open;
  int                 next_slot;
  logic [TIME_W-1:0]  sim_clock;
  logic [QUANT_W-1:0] quantum;

  slice_res_t pending_results[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_go     = 1'b0;
  bit hold_rx     = 1'b0;

  int n_sent     = 0;
  int n_checked  = 0;
  int n_fail     = 0;
  int n_slices   = 0;
  int n_finished = 0;
  int n_done     = 0;
  int n_full     = 0;

  function automatic slice_res_t rr_schedule(input logic op, input logic [ID_W-1:0] pid,
                                             input logic [TIME_W-1:0] arr,
                                             input logic [BURST_W-1:0] burst);
    slice_res_t r;
    int first, pick, idx, k, tat;
    bit hit;
    logic [BURST_W-1:0] q, len;
    r = '0;
    if (op == OP_LOAD) begin
      if (n_loaded >= NPROC) begin
        r.status = ST_FULL;
        return r;
      end
      tab_id[n_loaded]      = pid;
      tab_arrival[n_loaded] = arr;
      tab_burst[n_loaded]   = burst;
      tab_left[n_loaded]    = burst;
      n_loaded++;
      // a zero burst is stored but already counts as done
      if (burst != 0) n_open++;
      r.status = ST_LOAD;
      return r;
    end
    hit   = 1'b0;
    pick  = 0;
    first = (next_slot < n_loaded) ? next_slot : 0;
    if (n_open != 0) begin
      for (k = 0; k < n_loaded && !hit; k++) begin
        idx = first + k;
        if (idx >= n_loaded) idx -= n_loaded;
        if (tab_left[idx] != 0) begin
          pick = idx;
          hit  = 1'b1;
        end
      end
    end
    if (!hit) begin
      n_loaded  = 0;
      n_open    = 0;
      next_slot = 0;
      sim_clock = '0;
      r.status  = ST_DONE;
      return r;
    end
    q   = (quantum == 0) ? BURST_W'(1) : quantum;
    len = (tab_left[pick] <= q) ? tab_left[pick] : q;
    r.status       = ST_SLICE;
    r.served_id    = tab_id[pick];
    r.slice_start  = sim_clock;
    r.slice_length = len;
    sim_clock      = sim_clock + TIME_W'(len);
    tab_left[pick] = tab_left[pick] - len;
    if (tab_left[pick] == 0) begin
      tat          = int'(sim_clock) - int'(tab_arrival[pick]);
      r.finished   = 1'b1;
      r.turnaround = STAT_W'(tat);
      r.waiting    = STAT_W'(tat - int'(tab_burst[pick]));
      if (n_open != 0) n_open--;
    end
    next_slot = pick + 1;
    if (next_slot >= n_loaded) next_slot = 0;
    return r;
  endfunction

  // steps to run every loaded process out, plus the all-done step
  function automatic int steps_to_clear();
    int s, i, qe;
    qe = (quantum == 0) ? 1 : int'(quantum);
    s  = 1;
    for (i = 0; i < n_loaded; i++) s += (int'(tab_left[i]) + qe - 1) / qe;
    return s;
  endfunction

  // bursts mostly stay within three quanta (capped at 4095); modes 1 and 2 reach 4095 at wide quanta
  function automatic logic [BURST_W-1:0] pick_burst(input int bmode);
    int qe, hi;
    qe = (quantum == 0) ? 1 : int'(quantum);
    hi = (3 * qe > 4095) ? 4095 : 3 * qe;
    if ($urandom_range(99) < 8) return '0;
    if (bmode == 1 && qe >= 1024) return BURST_W'($urandom_range(4095, qe));
    if (bmode == 2 && qe >= 512) return BURST_W'($urandom);
    return BURST_W'($urandom_range(hi, 1));
  endfunction

  function automatic logic [TIME_W-1:0] pick_arrival();
    if ($urandom_range(1) == 0) return TIME_W'($urandom_range(2000, 0));
    return TIME_W'($urandom);
  endfunction

  // entered just after a falling edge, leaves just after one
  task automatic issue(input logic op, input logic [ID_W-1:0] pid,
                       input logic [TIME_W-1:0] arr, input logic [BURST_W-1:0] burst,
                       input bit typed, input status_t want);
    slice_res_t p, t;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.process_id    <= pid;
    req_ch.arrival_stamp <= arr;
    req_ch.burst_len     <= burst;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = rr_schedule(op, pid, arr, burst);
    if (typed) begin
      t        = '0;
      t.status = want;
      pending_results.push_back(t);
    end else begin
      pending_results.push_back(p);
    end
    n_sent++;
    @(negedge clk);
  endtask

  task automatic step_once();
    issue(OP_STEP, ID_W'($urandom), TIME_W'($urandom), BURST_W'($urandom), 1'b0, ST_SLICE);
  endtask

  task automatic run_out_table();
    while (n_loaded != 0) step_once();
  endtask

  // quantum is only written once every request has its result back
  task automatic set_quantum(input logic [QUANT_W-1:0] qv);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= qv;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    quantum = qv;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int sent0, r, nload, steps, mid, k, bmode;
    sent0 = n_sent;
    while (n_sent - sent0 < n_items) begin
      r = $urandom_range(99);
      if (r < 12) begin
        // noise: random mix of loads and steps
        nload = $urandom_range(6, 1);
        for (k = 0; k < nload; k++)
          issue(1'($urandom_range(1)), ID_W'($urandom), pick_arrival(),
                pick_burst($urandom_range(2)), 1'b0, ST_SLICE);
      end else begin
        bmode = $urandom_range(2);
        nload = (r < 27) ? $urandom_range(NPROC + 2, NPROC + 1) : $urandom_range(NPROC, 1);
        for (k = 0; k < nload; k++)
          issue(OP_LOAD, ID_W'($urandom), pick_arrival(), pick_burst(bmode), 1'b0, ST_SLICE);
        steps = steps_to_clear();
        if ($urandom_range(99) < 20) steps = $urandom_range(steps, 0);
        else if ($urandom_range(99) < 15) steps++;
        mid = ($urandom_range(99) < 25) ? $urandom_range(steps, 0) : -1;
        for (k = 0; k < steps; k++) begin
          // a load between steps joins the cycle at its table index
          if (k == mid)
            issue(OP_LOAD, ID_W'($urandom), pick_arrival(), pick_burst(bmode), 1'b0, ST_SLICE);
          step_once();
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_rx) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin : rx_hold
    int held;
    wait (hold_go);
    @(posedge clk);
    hold_rx = 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin : res_check
    slice_res_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.status       = status_t'(res_ch.status);
      got.served_id    = res_ch.served_id;
      got.slice_start  = res_ch.slice_start;
      got.slice_length = res_ch.slice_length;
      got.finished     = res_ch.finished;
      got.turnaround   = res_ch.turnaround;
      got.waiting      = res_ch.waiting;
      n_checked++;
      case (got.status)
        ST_SLICE: begin
          n_slices++;
          if (got.finished) n_finished++;
        end
        ST_DONE: n_done++;
        ST_FULL: n_full++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= SHOW_LIMIT)
          $display("%0t: result with no request outstanding: st=%0d id=%0d start=%0d len=%0d",
                   $realtime, got.status, got.served_id, got.slice_start, got.slice_length);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.served_id !== want.served_id ||
            got.slice_start !== want.slice_start || got.slice_length !== want.slice_length ||
            got.finished !== want.finished || got.turnaround !== want.turnaround ||
            got.waiting !== want.waiting) begin
          n_fail++;
          if (n_fail <= SHOW_LIMIT) begin
            $display("%0t: mismatch on result %0d", $realtime, n_checked);
            $display("  exp st=%0d id=%0d start=%0d len=%0d fin=%0d tat=%0d wait=%0d",
                     want.status, want.served_id, want.slice_start, want.slice_length,
                     want.finished, want.turnaround, want.waiting);
            $display("  got st=%0d id=%0d start=%0d len=%0d fin=%0d tat=%0d wait=%0d",
                     got.status, got.served_id, got.slice_start, got.slice_length,
                     got.finished, got.turnaround, got.waiting);
          end
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    int i;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_LOAD;
    req_ch.process_id    = '0;
    req_ch.arrival_stamp = '0;
    req_ch.burst_len     = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    res_ch.ready         = 1'b0;
    n_loaded  = 0;
    n_open    = 0;
    next_slot = 0;
    sim_clock = '0;
    quantum   = QUANT_W'(1);
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 14;
    rx_idle_pct = 56;

    // widest quantum: one slice finishes a full burst, negative turnaround
    rows.push_back('{ROW_CFG, OP_LOAD, 8'h00, 16'h0000, 12'h000, 12'd4095, 1'b0, ST_SLICE});
    rows.push_back('{ROW_REQ, OP_STEP, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b1, ST_DONE});
    rows.push_back('{ROW_REQ, OP_LOAD, 8'hff, 16'hffff, 12'hfff, 12'd0, 1'b1, ST_LOAD});
    rows.push_back('{ROW_REQ, OP_LOAD, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b1, ST_LOAD});
    rows.push_back('{ROW_REQ, OP_LOAD, 8'h81, 16'h0000, 12'h001, 12'd0, 1'b1, ST_LOAD});
    rows.push_back('{ROW_REQ, OP_STEP, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b0, ST_SLICE});
    rows.push_back('{ROW_REQ, OP_STEP, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b0, ST_SLICE});
    rows.push_back('{ROW_REQ, OP_STEP, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b1, ST_DONE});
    // zero quantum acts as one, then fill the table and overflow it
    rows.push_back('{ROW_CFG, OP_LOAD, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b0, ST_SLICE});
    rows.push_back('{ROW_REQ, OP_LOAD, 8'h7e, 16'h1234, 12'h003, 12'd0, 1'b1, ST_LOAD});
    for (i = 0; i < NPROC - 1; i++)
      rows.push_back('{ROW_REQ, OP_LOAD, 8'(i * 17 + 1), 16'(16'hfff0 + i), 12'(i % 3), 12'd0,
                       1'b1, ST_LOAD});
    rows.push_back('{ROW_REQ, OP_LOAD, 8'h5a, 16'h0000, 12'h005, 12'd0, 1'b1, ST_FULL});
    rows.push_back('{ROW_REQ, OP_STEP, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b0, ST_SLICE});
    rows.push_back('{ROW_REQ, OP_STEP, 8'h00, 16'h0000, 12'h000, 12'd0, 1'b0, ST_SLICE});

    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].kind == ROW_CFG) set_quantum(rows[i].qval);
      else issue(rows[i].op, rows[i].pid, rows[i].arr, rows[i].burst, rows[i].typed,
                 rows[i].want);
    end
    run_out_table();

    set_quantum(QUANT_W'(1));
    random_phase(PHASE_ITEMS);
    run_out_table();
    set_quantum(QUANT_W'(2000));
    random_phase(PHASE_ITEMS);
    run_out_table();

    tx_idle_pct = 56;
    rx_idle_pct = 14;
    set_quantum(QUANT_W'(4095));
    random_phase(PHASE_ITEMS);
    run_out_table();
    set_quantum(QUANT_W'(3));
    random_phase(PHASE_ITEMS);
    run_out_table();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_quantum(QUANT_W'($urandom_range(4095, 1)));
    // receiver stalls for a long stretch while requests keep coming
    hold_go = 1'b1;
    random_phase(PHASE_ITEMS);
    run_out_table();
    set_quantum(QUANT_W'(64));
    random_phase(PHASE_ITEMS);
    run_out_table();

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $write("run: %0d requests, %0d results checked: ", n_sent, n_checked);
    $display("%0d slices (%0d finishing), %0d all-done, %0d dropped loads",
             n_slices, n_finished, n_done, n_full);
    $display("quanta 0, 1, 3, 64, 2000, 4095 and a random one; idling both ways, one long hold");
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatched results", n_fail);
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_intf.sv
rtl/core/rrts_sched.sv
rtl/core/round_robin_time_slicer_top.sv
sim/tb_top.sv
